[rtl/core/lruht_pkg.sv]
`timescale 1ns / 1ps

package lruht_pkg;

  // Control half of the token that walks down the cell chain.
  typedef struct packed {
    logic valid;    // token holds an access
    logic pending;  // a key is still being carried toward an older slot
    logic hit;      // lookup matched a held key
    logic ev;       // carried key fell off the old end
  } lruht_tok_ctl_t;

endpackage

[rtl/core/lruht_cell.sv]
`timescale 1ns / 1ps

// One slot of the recency chain. Slot IDX is the IDX-th most recent key.
// The token enters with a carried key; the slot takes the carry and hands
// its own key onward until the lookup key or an empty slot is met.
module lruht_cell import lruht_pkg::*; #(
  parameter int KEY_BITS = 32,
  parameter int IDX      = 0,
  parameter int LIM_W    = 9
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic [LIM_W-1:0]    lim,
  input  lruht_tok_ctl_t      ctl_i,
  input  logic [KEY_BITS-1:0] skey_i,
  input  logic [KEY_BITS-1:0] ckey_i,
  output lruht_tok_ctl_t      ctl_o,
  output logic [KEY_BITS-1:0] skey_o,
  output logic [KEY_BITS-1:0] ckey_o
);

  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic                vld_r, vld_nxt;
  lruht_tok_ctl_t      ctl_r, ctl_nxt;
  logic [KEY_BITS-1:0] skey_r;
  logic [KEY_BITS-1:0] ckey_r, ckey_nxt;

  always_comb begin
    key_nxt  = key_r;
    vld_nxt  = vld_r;
    ctl_nxt  = ctl_i;
    ckey_nxt = ckey_i;
    if (ctl_i.valid && ctl_i.pending) begin
      if (vld_r && (key_r == skey_i)) begin
        // hit: this slot absorbs the carry, the chain above shifted by one
        key_nxt         = ckey_i;
        ctl_nxt.hit     = 1'b1;
        ctl_nxt.pending = 1'b0;
      end else if (vld_r) begin
        key_nxt  = ckey_i;
        ckey_nxt = key_r;
      end else if (IDX >= int'(lim)) begin
        // full at the limit: carry is the oldest key, drop it
        ctl_nxt.ev      = 1'b1;
        ctl_nxt.pending = 1'b0;
      end else begin
        key_nxt         = ckey_i;
        vld_nxt         = 1'b1;
        ctl_nxt.pending = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      ctl_r <= '0;
    end else if (adv) begin
      vld_r <= vld_nxt;
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      key_r  <= key_nxt;
      skey_r <= skey_i;
      ckey_r <= ckey_nxt;
    end
  end

  assign ctl_o  = ctl_r;
  assign skey_o = skey_r;
  assign ckey_o = ckey_r;

endmodule

[rtl/core/lru_cache_hit_tracker.sv]
`timescale 1ns / 1ps

// LRU page-key tracker. Keys live in a row of MAX_SLOTS cells ordered from
// most recent (cell 0) to least recent. Each accepted word starts a token
// at cell 0 that moves one cell per cycle while the chain advances,
// comparing against and shifting the held keys as it goes, so a new word
// can enter every cycle and the block sustains one word per clock unless
// the output stalls. The token is registered in cell 0, then in each later
// cell in turn, and the output register takes it from the last cell. A
// stalled output freezes the whole chain.
// On a miss with the cache already at slots_in_use entries the oldest key
// is evicted; lowering slots_in_use below the current fill does not shrink
// the cache, each later miss just evicts one key. slots_in_use of zero acts
// as one, values above MAX_SLOTS act as MAX_SLOTS. Write it only while no
// word is in flight. Both totals saturate at all ones. No clearing pass is
// needed after reset.
module lru_cache_hit_tracker import lruht_pkg::*; #(
  parameter int MAX_SLOTS = 256,
  parameter int KEY_BITS  = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // config
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [8:0]  cfg_slots_in_use,
  // access words
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_page_key,
  // result words
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_hit,
  output logic        out_evicted_valid,
  output logic [31:0] out_evicted_key,
  output logic [31:0] out_hit_total,
  output logic [31:0] out_access_total
);

  localparam int LIM_W   = $clog2(MAX_SLOTS + 1);
  localparam int LIM_RST = (256 > MAX_SLOTS) ? MAX_SLOTS : 256;

  // effective slot limit, already clamped to 1..MAX_SLOTS
  logic [LIM_W-1:0] lim_r, lim_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    if (cfg_slots_in_use == 9'd0) begin
      lim_nxt = LIM_W'(1);
    end else if (int'(cfg_slots_in_use) > MAX_SLOTS) begin
      lim_nxt = LIM_W'(MAX_SLOTS);
    end else begin
      lim_nxt = LIM_W'(cfg_slots_in_use);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r <= LIM_W'(LIM_RST);
    end else if (cfg_valid && cfg_ready) begin
      lim_r <= lim_nxt;
    end
  end

  // chain advances whenever the output register can take a word
  logic adv;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  lruht_tok_ctl_t      tok_ctl  [MAX_SLOTS+1];
  logic [KEY_BITS-1:0] tok_skey [MAX_SLOTS+1];
  logic [KEY_BITS-1:0] tok_ckey [MAX_SLOTS+1];

  // fresh token: the new key is carried in as most recent
  assign tok_ctl[0]  = '{valid: in_valid, pending: 1'b1, hit: 1'b0, ev: 1'b0};
  assign tok_skey[0] = KEY_BITS'(in_page_key);
  assign tok_ckey[0] = KEY_BITS'(in_page_key);

  for (genvar g = 0; g < MAX_SLOTS; g++) begin : g_cell
    lruht_cell #(
      .KEY_BITS (KEY_BITS),
      .IDX      (g),
      .LIM_W    (LIM_W)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv),
      .lim    (lim_r),
      .ctl_i  (tok_ctl[g]),
      .skey_i (tok_skey[g]),
      .ckey_i (tok_ckey[g]),
      .ctl_o  (tok_ctl[g+1]),
      .skey_o (tok_skey[g+1]),
      .ckey_o (tok_ckey[g+1])
    );
  end

  // tail of the chain: still carrying means every slot was full, so evict
  lruht_tok_ctl_t tail;
  logic           tail_ev;
  assign tail    = tok_ctl[MAX_SLOTS];
  assign tail_ev = tail.ev || tail.pending;

  logic        out_valid_r;
  logic        hit_r, ev_r;
  logic [31:0] ev_key_r, ev_key_nxt;
  logic [31:0] hit_cnt_r, hit_cnt_nxt;
  logic [31:0] acc_cnt_r, acc_cnt_nxt;

  always_comb begin
    ev_key_nxt  = tail_ev ? 32'(tok_ckey[MAX_SLOTS]) : 32'd0;
    acc_cnt_nxt = (acc_cnt_r == '1) ? acc_cnt_r : acc_cnt_r + 32'd1;
    hit_cnt_nxt = hit_cnt_r;
    if (tail.hit && (hit_cnt_r != '1)) begin
      hit_cnt_nxt = hit_cnt_r + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      hit_cnt_r   <= '0;
      acc_cnt_r   <= '0;
    end else if (adv) begin
      out_valid_r <= tail.valid;
      if (tail.valid) begin
        hit_cnt_r <= hit_cnt_nxt;
        acc_cnt_r <= acc_cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && tail.valid) begin
      hit_r    <= tail.hit;
      ev_r     <= tail_ev;
      ev_key_r <= ev_key_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = hit_r;
  assign out_evicted_valid = ev_r;
  assign out_evicted_key   = ev_key_r;
  assign out_hit_total     = hit_cnt_r;
  assign out_access_total  = acc_cnt_r;

endmodule

[rtl/core/lruht_chk.sv]
`timescale 1ns / 1ps

module lruht_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [8:0]  cfg_slots_in_use,
  input logic        in_valid,
  input logic        in_stall,
  input logic [31:0] in_page_key,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_hit,
  input logic        out_evicted_valid,
  input logic [31:0] out_evicted_key,
  input logic [31:0] out_hit_total,
  input logic [31:0] out_access_total
);

  // a hit never evicts
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> !out_evicted_valid)
    else $error("eviction reported on a hit");

  // evicted key reads zero when nothing was evicted
  a_ev_key_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_evicted_valid |-> out_evicted_key == 32'd0)
    else $error("evicted key nonzero without eviction");

  a_hits_le_access: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_hit_total <= out_access_total)
    else $error("hit total exceeds access total");

  // back-to-back words: access total steps by one unless saturated
  a_access_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall) ##1 out_valid |->
      (out_access_total == $past(out_access_total) + 32'd1) ||
      (out_access_total == 32'hFFFF_FFFF))
    else $error("access total did not advance by one");

endmodule

bind lru_cache_hit_tracker lruht_chk u_lruht_chk (.*);

[dv/tb_lru_cache_hit_tracker.sv]
`timescale 1ns / 1ps

module tb_lru_cache_hit_tracker;

  localparam int MAX_SLOTS = 256;
  localparam int KEY_BITS = 32;
  // long receiver hold-off, in clocks; well past the chain depth so the
  // block fills and pushes back on its input
  localparam int HOLD_OFF_CYCLES = 800;
  localparam int DRAIN_LIMIT = 200000;

  // receiver behavior over one stretch of clocks
  typedef enum int {
    STALL_NONE,
    STALL_COIN,
    STALL_HEAVY,
    STALL_PERIODIC,
    STALL_HOLD
  } stall_mode_e;

  // one result word, field for field as it leaves the block
  typedef struct packed {
    logic        hit;
    logic        evicted_valid;
    logic [31:0] evicted_key;
    logic [31:0] hit_total;
    logic [31:0] access_total;
  } access_result_t;

  // Mirrors the recency list and the running totals, and keeps the
  // outcomes of accepted accesses in order until their words show up.
  class lru_scoreboard;
    logic [8:0]     slot_cfg;
    logic [31:0]    held_keys[$];       // oldest key at index 0
    access_result_t access_outcomes[$];
    logic [31:0]    hit_count;
    logic [31:0]    access_count;
    int unsigned    errors;

    function new();
      slot_cfg = 9'd256;
      hit_count = '0;
      access_count = '0;
      errors = 0;
    endfunction

    function void set_slots(logic [8:0] v);
      slot_cfg = v;
    endfunction

    // work out what the block must report for this access
    function void note_access(logic [31:0] key);
      access_result_t r;
      int pos;
      int limit;
      r = '0;
      pos = -1;
      if (access_count != 32'hFFFF_FFFF) access_count++;
      for (int i = 0; i < held_keys.size(); i++) begin
        if (held_keys[i] == key) begin
          pos = i;
          break;
        end
      end
      if (pos >= 0) begin
        // hit: move to the most recent end
        held_keys.delete(pos);
        held_keys.push_back(key);
        if (hit_count != 32'hFFFF_FFFF) hit_count++;
        r.hit = 1'b1;
      end else begin
        // zero acts as one, anything past the array acts as full size
        limit = (slot_cfg == 0) ? 1 : ((slot_cfg > MAX_SLOTS) ? MAX_SLOTS : slot_cfg);
        // a lowered limit only costs one eviction per miss; fill never shrinks
        if (held_keys.size() >= limit && held_keys.size() > 0) begin
          r.evicted_valid = 1'b1;
          r.evicted_key = held_keys.pop_front();
        end
        if (held_keys.size() < MAX_SLOTS) held_keys.push_back(key);
      end
      r.hit_total = hit_count;
      r.access_total = access_count;
      access_outcomes.push_back(r);
    endfunction

    function void check_result(access_result_t got);
      access_result_t want;
      if (access_outcomes.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: unexpected word: hit=%0b ev=%0b evkey=%08h hits=%0d acc=%0d",
                   $time, got.hit, got.evicted_valid, got.evicted_key, got.hit_total,
                   got.access_total);
        return;
      end
      want = access_outcomes.pop_front();
      if (got.hit !== want.hit || got.evicted_valid !== want.evicted_valid ||
          got.evicted_key !== want.evicted_key || got.hit_total !== want.hit_total ||
          got.access_total !== want.access_total) begin
        errors++;
        if (errors <= 10) begin
          $display("%0t: mismatch exp hit=%0b ev=%0b evkey=%08h hits=%0d acc=%0d",
                   $time, want.hit, want.evicted_valid, want.evicted_key, want.hit_total,
                   want.access_total);
          $display("%0t:          got hit=%0b ev=%0b evkey=%08h hits=%0d acc=%0d",
                   $time, got.hit, got.evicted_valid, got.evicted_key, got.hit_total,
                   got.access_total);
        end
      end
    endfunction
  endclass

  // every input known from time zero
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [8:0]  cfg_slots_in_use = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_page_key = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_hit;
  logic        out_evicted_valid;
  logic [31:0] out_evicted_key;
  logic [31:0] out_hit_total;
  logic [31:0] out_access_total;

  lru_scoreboard  sb = new();
  int             burst_left = 0;   // words left in the sender's current burst
  bit             hold_off_req = 1'b0;
  logic [31:0]    key_pool[$];      // shared across phases so old keys come back
  access_result_t seen_word;

  lru_cache_hit_tracker #(
    .MAX_SLOTS(MAX_SLOTS),
    .KEY_BITS (KEY_BITS)
  ) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_slots_in_use (cfg_slots_in_use),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_page_key      (in_page_key),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_hit          (out_hit),
    .out_evicted_valid(out_evicted_valid),
    .out_evicted_key  (out_evicted_key),
    .out_hit_total    (out_hit_total),
    .out_access_total (out_access_total)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Sender: bursts of random length, random gaps between them. valid stays
  // up across a burst and the key holds while the block stalls.
  task automatic send_access(input logic [31:0] key);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 48);
    end
    in_valid    <= 1'b1;
    in_page_key <= key;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_access(key);
    burst_left--;
  endtask

  // drop valid and let every outstanding word come back
  task automatic idle_wait();
    int n;
    in_valid <= 1'b0;
    burst_left = 0;
    n = 0;
    while (sb.access_outcomes.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
  endtask

  // only called with nothing in flight
  task automatic write_slots(input logic [8:0] slots);
    cfg_valid        <= 1'b1;
    cfg_slots_in_use <= slots;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    sb.set_slots(slots);
  endtask

  // Mostly reuse of a key pool (hits, recency reorder), some fresh keys
  // (misses, evictions once the limit is reached).
  task automatic run_phase(input logic [8:0] slots, input int n_items, input int pool_size);
    logic [31:0] key;
    write_slots(slots);
    while (key_pool.size() < pool_size) key_pool.push_back($urandom);
    repeat (n_items) begin
      if ($urandom_range(0, 99) < 85) key = key_pool[$urandom_range(0, pool_size - 1)];
      else key = $urandom;
      send_access(key);
    end
    idle_wait();
  endtask

  // Receiver: stretches of no stall, coin flips, heavy and periodic
  // stalls, plus one long hold-off on request.
  initial begin : rx_pattern
    stall_mode_e mode;
    int stretch;
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        mode = STALL_HOLD;
        stretch = HOLD_OFF_CYCLES;
      end else begin
        mode = stall_mode_e'($urandom_range(0, 3));
        stretch = $urandom_range(4, 60);
      end
      for (int c = 0; c < stretch; c++) begin
        @(posedge clk);
        case (mode)
          STALL_NONE:     out_stall <= 1'b0;
          STALL_COIN:     out_stall <= 1'($urandom_range(0, 1));
          STALL_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
          STALL_PERIODIC: out_stall <= (c % 3 == 2);
          default:        out_stall <= 1'b1;
        endcase
      end
    end
  end

  // every accepted result word goes to the scoreboard
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      seen_word.hit           = out_hit;
      seen_word.evicted_valid = out_evicted_valid;
      seen_word.evicted_key   = out_evicted_key;
      seen_word.hit_total     = out_hit_total;
      seen_word.access_total  = out_access_total;
      sb.check_result(seen_word);
    end
  end

  initial begin : stimulus
    // reset limit of 256: extremes, repeats that hit and reorder
    logic [31:0] warm_keys[10] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000,
                                   32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_FFFF,
                                   32'h8000_0000, 32'h0000_0001, 32'h0000_0000,
                                   32'h1234_5678};
    // limit of one, well below the fill: each miss evicts just the oldest
    logic [31:0] shrink_keys[4] = '{32'h0000_0000, 32'hDEAD_BEEF, 32'hCAFE_F00D,
                                    32'h0000_0000};
    // limit of zero, treated as one
    logic [31:0] zero_keys[3] = '{32'h1357_9BDF, 32'h1357_9BDF, 32'h2468_ACE0};
    // limit past the array size, clamps to full
    logic [31:0] over_keys[3] = '{32'hFFFF_FFFE, 32'h7FFF_FFFF, 32'hFFFF_FFFE};
    // limits mostly rising, with a drop to 3: the fill never goes back down
    logic [8:0] phase_slots[6] = '{9'd16, 9'd40, 9'd3, 9'd100, 9'd256, 9'd511};
    int phase_items[6] = '{120, 120, 100, 320, 250, 200};
    int phase_pool[6]  = '{24, 60, 48, 140, 360, 300};

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (warm_keys[i]) send_access(warm_keys[i]);
    idle_wait();
    write_slots(9'd1);
    foreach (shrink_keys[i]) send_access(shrink_keys[i]);
    idle_wait();
    write_slots(9'd0);
    foreach (zero_keys[i]) send_access(zero_keys[i]);
    idle_wait();
    write_slots(9'd511);
    foreach (over_keys[i]) send_access(over_keys[i]);
    idle_wait();

    for (int p = 0; p < 6; p++) begin
      // back pressure: receiver holds off while the sender keeps offering
      if (p == 3) hold_off_req = 1'b1;
      run_phase(phase_slots[p], phase_items[p], phase_pool[p]);
    end

    // catch stray words for a chain length and then some
    repeat (MAX_SLOTS + 50) @(posedge clk);
    if (sb.errors == 0 && sb.access_outcomes.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // hang guard, far above the slowest legal run
  initial begin : watchdog
    #(5_000_000);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
